### src/c2u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_pkg: shared types and constants
// Widths, UTF-8 length thresholds, lead markers and the encoded
// sequence type used by the codepage to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package c2u_pkg;

   localparam int BYTE_WIDTH  = 8;
   localparam int CP_WIDTH    = 31;
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_SEQ_LEN = 6;
   localparam int LEN_WIDTH   = 3;
   localparam int CONT_BITS   = 6;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_XLATE = 1'b1
   } func_type;

   localparam logic [CP_WIDTH-1:0] LIMIT_LEN1 = 31'h0000_0080;
   localparam logic [CP_WIDTH-1:0] LIMIT_LEN2 = 31'h0000_0800;
   localparam logic [CP_WIDTH-1:0] LIMIT_LEN3 = 31'h0001_0000;
   localparam logic [CP_WIDTH-1:0] LIMIT_LEN4 = 31'h0020_0000;
   localparam logic [CP_WIDTH-1:0] LIMIT_LEN5 = 31'h0400_0000;

   localparam logic [BYTE_WIDTH-1:0] LEAD_LEN2 = 8'hc0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_LEN3 = 8'he0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_LEN4 = 8'hf0;
   localparam logic [BYTE_WIDTH-1:0] LEAD_LEN5 = 8'hf8;
   localparam logic [BYTE_WIDTH-1:0] LEAD_LEN6 = 8'hfc;
   localparam logic [1:0]            CONT_MARK = 2'b10;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]                     len;
      logic [MAX_SEQ_LEN-1:0][BYTE_WIDTH-1:0]   seq;
   } utf8_seq_type;

endpackage

### src/c2u_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_req_if: request channel
// Valid/ready channel carrying load and translate requests.
// ----------------------------------------------------------------------------
interface c2u_req_if;

   logic                              valid;
   logic                              ready;
   logic                              func;
   logic [c2u_pkg::BYTE_WIDTH-1:0]    src_byte;
   logic [c2u_pkg::CP_WIDTH-1:0]      code_point;
   logic                              end_of_string;

   modport source (
      output valid, func, src_byte, code_point, end_of_string,
      input  ready
   );

   modport sink (
      input  valid, func, src_byte, code_point, end_of_string,
      output ready
   );

endinterface

### src/c2u_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_rsp_if: response channel
// Valid/ready channel carrying one UTF-8 byte per transfer.
// ----------------------------------------------------------------------------
interface c2u_rsp_if;

   logic                              valid;
   logic                              ready;
   logic [c2u_pkg::BYTE_WIDTH-1:0]    out_byte;
   logic                              last_of_char;
   logic                              string_done;

   modport source (
      output valid, out_byte, last_of_char, string_done,
      input  ready
   );

   modport sink (
      input  valid, out_byte, last_of_char, string_done,
      output ready
   );

endinterface

### src/c2u_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_ram: generic single-port-write RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module c2u_ram #(
   parameter int WIDTH = c2u_pkg::CP_WIDTH,
   parameter int DEPTH = c2u_pkg::TABLE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/c2u_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_encoder: code point to UTF-8 sequence
// Picks the sequence length from the code point and builds the lead
// byte and continuation bytes, lead byte in the lowest lane.
// ----------------------------------------------------------------------------
module c2u_encoder (
   input  logic [c2u_pkg::CP_WIDTH-1:0] code_point,
   output c2u_pkg::utf8_seq_type        seq
);

   logic [c2u_pkg::MAX_SEQ_LEN-2:0][c2u_pkg::BYTE_WIDTH-1:0] cont;
   logic [c2u_pkg::LEN_WIDTH-1:0]                            len;

   always_comb begin
      for (int j = 0; j < c2u_pkg::MAX_SEQ_LEN - 1; j++) begin
         cont[j] = {c2u_pkg::CONT_MARK,
                    code_point[j*c2u_pkg::CONT_BITS +: c2u_pkg::CONT_BITS]};
      end
   end

   always_comb begin
      priority if (code_point < c2u_pkg::LIMIT_LEN1) begin
         len = 3'd1;
      end else if (code_point < c2u_pkg::LIMIT_LEN2) begin
         len = 3'd2;
      end else if (code_point < c2u_pkg::LIMIT_LEN3) begin
         len = 3'd3;
      end else if (code_point < c2u_pkg::LIMIT_LEN4) begin
         len = 3'd4;
      end else if (code_point < c2u_pkg::LIMIT_LEN5) begin
         len = 3'd5;
      end else begin
         len = 3'd6;
      end
   end

   always_comb begin
      seq.len = len;
      seq.seq = '0;
      unique case (len)
         3'd1: begin
            seq.seq[0] = {1'b0, code_point[6:0]};
         end
         3'd2: begin
            seq.seq[0] = c2u_pkg::LEAD_LEN2 | {3'b000, code_point[10:6]};
            seq.seq[1] = cont[0];
         end
         3'd3: begin
            seq.seq[0] = c2u_pkg::LEAD_LEN3 | {4'b0000, code_point[15:12]};
            seq.seq[1] = cont[1];
            seq.seq[2] = cont[0];
         end
         3'd4: begin
            seq.seq[0] = c2u_pkg::LEAD_LEN4 | {5'b00000, code_point[20:18]};
            seq.seq[1] = cont[2];
            seq.seq[2] = cont[1];
            seq.seq[3] = cont[0];
         end
         3'd5: begin
            seq.seq[0] = c2u_pkg::LEAD_LEN5 | {6'b000000, code_point[25:24]};
            seq.seq[1] = cont[3];
            seq.seq[2] = cont[2];
            seq.seq[3] = cont[1];
            seq.seq[4] = cont[0];
         end
         3'd6: begin
            seq.seq[0] = c2u_pkg::LEAD_LEN6 | {7'b0000000, code_point[30]};
            seq.seq[1] = cont[4];
            seq.seq[2] = cont[3];
            seq.seq[3] = cont[2];
            seq.seq[4] = cont[1];
            seq.seq[5] = cont[0];
         end
         default: begin
            seq.seq = '0;
         end
      endcase
   end

endmodule

### src/c2u_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2u_emitter: UTF-8 byte serializer
// Holds one encoded sequence and drives it onto the response channel
// one byte per transfer, marking the last byte of each character.
// ----------------------------------------------------------------------------
module c2u_emitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  c2u_pkg::utf8_seq_type in_seq,
   input  logic                  in_eos,
   c2u_rsp_if.source             rsp_chan
);

   logic [c2u_pkg::LEN_WIDTH-1:0]                            cnt_ff, cnt_in;
   logic [c2u_pkg::MAX_SEQ_LEN-1:0][c2u_pkg::BYTE_WIDTH-1:0] seq_ff, seq_in;
   logic                                                     eos_ff, eos_in;
   logic                                                     take;
   logic                                                     in_fire;

   assign take     = rsp_chan.valid && rsp_chan.ready;
   assign in_ready = (cnt_ff == '0) || ((cnt_ff == 3'd1) && rsp_chan.ready);
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      cnt_in = cnt_ff;
      seq_in = seq_ff;
      eos_in = eos_ff;
      priority if (in_fire) begin
         cnt_in = in_seq.len;
         seq_in = in_seq.seq;
         eos_in = in_eos;
      end else if (take) begin
         cnt_in = cnt_ff - 3'd1;
         seq_in = seq_ff >> c2u_pkg::BYTE_WIDTH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      seq_ff <= seq_in;
      eos_ff <= eos_in;
   end

   assign rsp_chan.valid        = (cnt_ff != '0);
   assign rsp_chan.out_byte     = seq_ff[0];
   assign rsp_chan.last_of_char = (cnt_ff == 3'd1);
   assign rsp_chan.string_done  = (cnt_ff == 3'd1) && eos_ff;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'd6)
      else $error("emitter byte count out of range");

   a_seq_continues: assert property (@(posedge clock) disable iff (reset)
      take && !rsp_chan.last_of_char |=>
         rsp_chan.valid && (!in_fire || (take && rsp_chan.last_of_char)))
      else $error("sequence interrupted before its last byte");

   a_load_on_last: assert property (@(posedge clock) disable iff (reset)
      in_fire && (cnt_ff != '0) |-> take && rsp_chan.last_of_char)
      else $error("new sequence loaded over undelivered bytes");

endmodule

### src/codepage_to_utf8_transcoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codepage_to_utf8_transcoder_core: codepage to UTF-8 transcoder
// Translates single-byte codepage characters to UTF-8 through a
// loadable 256-entry code point table.
// ----------------------------------------------------------------------------
// Path: a translate request's table read and hit flag are registered in
//   stage 1, then loaded into the emitter, which presents the first byte.
// Throughput: one request per cycle unless stage 1 waits on a busy output;
//   an n-byte character takes n output transfers; the response port sets the rate.
// Load requests produce no response and are taken one per cycle unless a
//   translate request waits in the input register behind a busy output.
// Reset: synchronous; all table entries read as zero right after reset,
//   with no clearing pass.
// ----------------------------------------------------------------------------
module codepage_to_utf8_transcoder_core (
   input  logic       clock,
   input  logic       reset,
   c2u_req_if.sink    req_chan,
   c2u_rsp_if.source  rsp_chan
);

   logic                                 req_fire;
   logic                                 load_fire;
   logic                                 xlate_fire;
   logic [c2u_pkg::TABLE_DEPTH-1:0]      mapped_ff, mapped_in;
   logic                                 s1_valid_ff, s1_valid_in;
   logic                                 s1_hit_ff;
   logic                                 s1_eos_ff;
   logic                                 s1_adv;
   logic                                 emit_ready;
   logic [c2u_pkg::CP_WIDTH-1:0]         rd_data;
   logic [c2u_pkg::CP_WIDTH-1:0]         s1_code_point;
   c2u_pkg::utf8_seq_type                s1_seq;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign load_fire  = req_fire && (req_chan.func == c2u_pkg::FUNC_LOAD);
   assign xlate_fire = req_fire && (req_chan.func == c2u_pkg::FUNC_XLATE);
   assign s1_adv     = s1_valid_ff && emit_ready;
   assign req_chan.ready = !s1_valid_ff || emit_ready;

   c2u_ram #(
      .WIDTH (c2u_pkg::CP_WIDTH),
      .DEPTH (c2u_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (req_chan.src_byte),
      .wr_data (req_chan.code_point),
      .rd_en   (xlate_fire),
      .rd_addr (req_chan.src_byte),
      .rd_data (rd_data)
   );

   always_comb begin
      mapped_in = mapped_ff;
      if (load_fire) begin
         mapped_in[req_chan.src_byte] = 1'b1;
      end
   end

   always_comb begin
      priority if (xlate_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mapped_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         mapped_ff   <= mapped_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (xlate_fire) begin
         s1_hit_ff <= mapped_ff[req_chan.src_byte];
         s1_eos_ff <= req_chan.end_of_string;
      end
   end

   assign s1_code_point = s1_hit_ff ? rd_data : '0;

   c2u_encoder u_encoder (
      .code_point (s1_code_point),
      .seq        (s1_seq)
   );

   c2u_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (emit_ready),
      .in_seq   (s1_seq),
      .in_eos   (s1_eos_ff),
      .rsp_chan (rsp_chan)
   );

endmodule
